// ===== hw/rtl/kpc_pkg.sv =====
// ============================================================================
// kpc_pkg: shared types and constants of the keyframe playback clock
// Holds the play-state codes, register indexes, reset values and the
// command and status groups between the controller and the datapath.
// ============================================================================
package kpc_pkg;

    // Field widths.
    localparam int W_TIME   = 24;
    localparam int W_DELTA  = 16;
    localparam int W_FRAC   = 16;
    localparam int W_WEIGHT = 17;
    localparam int W_LOOPS  = 16;
    localparam int W_STATE  = 2;
    localparam int W_CFG_IX = 3;
    localparam int W_PROD   = W_TIME + W_WEIGHT;
    localparam int W_DIVIDEND = W_TIME + W_FRAC;
    localparam int W_DIV_CNT  = 6;

    // Play-state codes.
    localparam logic [W_STATE-1:0] MODE_STOP     = 2'd0;
    localparam logic [W_STATE-1:0] MODE_FADE_IN  = 2'd1;
    localparam logic [W_STATE-1:0] MODE_PLAY     = 2'd2;
    localparam logic [W_STATE-1:0] MODE_FADE_OUT = 2'd3;

    // Operation codes of an input word.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes.
    localparam logic [W_CFG_IX-1:0] CFG_CLIP_LENGTH   = 3'd0;
    localparam logic [W_CFG_IX-1:0] CFG_KEY_PERIOD    = 3'd1;
    localparam logic [W_CFG_IX-1:0] CFG_LOOP_ENABLE   = 3'd2;
    localparam logic [W_CFG_IX-1:0] CFG_FADE_IN_TIME  = 3'd3;
    localparam logic [W_CFG_IX-1:0] CFG_FADE_OUT_TIME = 3'd4;
    localparam logic [W_CFG_IX-1:0] CFG_TARGET_WEIGHT = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [W_TIME-1:0]   RST_CLIP_LENGTH   = 24'd65536;
    localparam logic [W_TIME-1:0]   RST_KEY_PERIOD    = 24'd2184;
    localparam logic                RST_LOOP_ENABLE   = 1'b0;
    localparam logic [W_TIME-1:0]   RST_FADE_IN_TIME  = 24'd0;
    localparam logic [W_TIME-1:0]   RST_FADE_OUT_TIME = 24'd6554;
    localparam logic [W_WEIGHT-1:0] RST_TARGET_WEIGHT = 17'd65536;

    localparam logic [W_TIME-1:0]   TIME_MAX = 24'hFFFFFF;
    localparam logic [W_WEIGHT-1:0] ONE_Q16  = 17'd65536;

    // The key division runs over the position and sixteen fraction bits.
    // The weight division starts with the top of the product preloaded.
    localparam logic [W_DIV_CNT-1:0] KEY_DIV_STEPS    = 6'd40;
    localparam logic [W_DIV_CNT-1:0] WEIGHT_DIV_STEPS = 6'd17;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input word
        logic start;    // restart playback
        logic advance;  // form the saturated position and ramp sums
        logic wrap;     // clip-end check and position update
        logic ramp;     // fade-in and fade-out decisions
        logic mul;      // weight numerator product
        logic kgo;      // launch the key division
        logic ktake;    // store key index and fraction
        logic wgo;      // launch the weight division
        logic wtake;    // store blend weight
        logic publish;  // load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_start;
        logic mode_stop;
        logic kneed;
        logic wneed;
        logic div_busy;
    } t_sts;

endpackage

// ===== hw/rtl/kpc_divider.sv =====
// ============================================================================
// kpc_divider: shared restoring divider
// Produces one quotient bit per cycle. The dividend bits shift out of the
// top of a register while the quotient bits shift into its bottom.
// ============================================================================
module kpc_divider import kpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [W_TIME-1:0]     i_rem,
    input  logic [W_DIVIDEND-1:0] i_dividend,
    input  logic [W_TIME-1:0]     i_divisor,
    input  logic [W_DIV_CNT-1:0]  i_steps,
    output logic                  o_busy,
    output logic [W_DIVIDEND-1:0] o_quot
);

    logic [W_DIV_CNT-1:0]  r_cnt;
    logic [W_TIME-1:0]     r_rem;
    logic [W_DIVIDEND-1:0] r_shf;
    logic [W_TIME-1:0]     r_div;

    logic [W_TIME:0]       trial;
    logic [W_TIME:0]       diff;
    logic                  qbit;
    logic [W_TIME-1:0]     n_rem;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        trial = {r_rem, r_shf[W_DIVIDEND-1]};
        diff  = trial - {1'b0, r_div};
        qbit  = (trial >= {1'b0, r_div});
        n_rem = qbit ? diff[W_TIME-1:0] : trial[W_TIME-1:0];
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_go) begin
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Remainder, shift register and divisor.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= i_rem;
            r_shf <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_shf <= {r_shf[W_DIVIDEND-2:0], qbit};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_shf;

endmodule

// ===== hw/rtl/kpc_datapath.sv =====
// ============================================================================
// kpc_datapath: playback state, configuration and arithmetic
// Holds the configuration registers, the playback state, the per-word
// working registers, the shared divider and the output register.
// ============================================================================
module kpc_datapath import kpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [W_CFG_IX-1:0]   i_cfg_idx,
    input  logic [W_TIME-1:0]     i_cfg_data,
    input  logic                  i_op,
    input  logic [W_DELTA-1:0]    i_time_delta,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [W_STATE-1:0]    o_play_state,
    output logic [W_TIME-1:0]     o_key_index,
    output logic [W_FRAC-1:0]     o_key_fraction,
    output logic [W_WEIGHT-1:0]   o_blend_weight,
    output logic [W_LOOPS-1:0]    o_loops_done
);

    // Configuration registers.
    logic [W_TIME-1:0]   r_clip;
    logic [W_TIME-1:0]   r_kper;
    logic                r_loop;
    logic [W_TIME-1:0]   r_fin;
    logic [W_TIME-1:0]   r_fot;
    logic [W_WEIGHT-1:0] r_tgt;

    // Playback state.
    logic [W_STATE-1:0]  r_mode;
    logic [W_TIME-1:0]   r_pos;
    logic [W_TIME-1:0]   r_ramp;
    logic [W_TIME-1:0]   r_key;
    logic [W_FRAC-1:0]   r_ratio;
    logic [W_WEIGHT-1:0] r_weight;
    logic [W_LOOPS-1:0]  r_wrap;

    // Working registers of the word in progress.
    logic                r_op;
    logic [W_DELTA-1:0]  r_delta;
    logic [W_TIME-1:0]   r_psum;
    logic [W_TIME-1:0]   r_rsum;
    logic [W_TIME-1:0]   r_rnew;
    logic                r_wrapped;
    logic                r_kneed;
    logic                r_wneed;
    logic [W_TIME-1:0]   r_x;
    logic [W_TIME-1:0]   r_wdiv;
    logic [W_PROD-1:0]   r_num;

    // Output register.
    logic [W_STATE-1:0]  r_o_state;
    logic [W_TIME-1:0]   r_o_key;
    logic [W_FRAC-1:0]   r_o_frac;
    logic [W_WEIGHT-1:0] r_o_weight;
    logic [W_LOOPS-1:0]  r_o_loops;

    logic [W_WEIGHT-1:0]   tgt_eff;
    logic [W_TIME-1:0]     kper_eff;
    logic [W_TIME:0]       pos_add;
    logic [W_TIME:0]       ramp_add;
    logic                  wrap_active;
    logic                  wrapped;
    logic                  go_out;
    logic [W_TIME-1:0]     pos_wrapped;
    logic                  fin_done;
    logic                  fo_over;
    logic [W_TIME-1:0]     fo_left;
    logic                  div_go;
    logic [W_TIME-1:0]     div_rem;
    logic [W_DIVIDEND-1:0] div_dividend;
    logic [W_TIME-1:0]     div_divisor;
    logic [W_DIV_CNT-1:0]  div_steps;
    logic                  div_busy;
    logic [W_DIVIDEND-1:0] div_quot;

    // Effective target and key period.
    assign tgt_eff  = (r_tgt > ONE_Q16) ? ONE_Q16 : r_tgt;
    assign kper_eff = (r_kper == '0) ? W_TIME'(1) : r_kper;

    // Raw sums for the advance step.
    assign pos_add  = {1'b0, r_pos} + {{(W_TIME-W_DELTA+1){1'b0}}, r_delta};
    assign ramp_add = {1'b0, r_ramp} + {{(W_TIME-W_DELTA+1){1'b0}}, r_delta};

    // Clip-end check; only fade-in and play move the position.
    assign wrap_active = (r_mode == MODE_FADE_IN) || (r_mode == MODE_PLAY);
    assign wrapped     = wrap_active && (r_psum > r_clip);
    assign go_out      = wrapped && !r_loop;
    assign pos_wrapped = r_psum - r_clip;

    // Ramp checks against the fade times.
    assign fin_done = !(r_rnew < r_fin);
    assign fo_over  = (r_rnew > r_fot);
    assign fo_left  = r_fot - r_rnew;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= RST_CLIP_LENGTH;
            r_kper <= RST_KEY_PERIOD;
            r_loop <= RST_LOOP_ENABLE;
            r_fin  <= RST_FADE_IN_TIME;
            r_fot  <= RST_FADE_OUT_TIME;
            r_tgt  <= RST_TARGET_WEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLIP_LENGTH:   r_clip <= i_cfg_data;
                CFG_KEY_PERIOD:    r_kper <= i_cfg_data;
                CFG_LOOP_ENABLE:   r_loop <= i_cfg_data[0];
                CFG_FADE_IN_TIME:  r_fin  <= i_cfg_data;
                CFG_FADE_OUT_TIME: r_fot  <= i_cfg_data;
                CFG_TARGET_WEIGHT: r_tgt  <= i_cfg_data[W_WEIGHT-1:0];
                default: begin
                end
            endcase
        end
    end

    // Playback state and the need flags, updated step by step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_STOP;
            r_pos     <= '0;
            r_ramp    <= '0;
            r_key     <= '0;
            r_ratio   <= '0;
            r_weight  <= '0;
            r_wrap    <= '0;
            r_kneed   <= 1'b0;
            r_wneed   <= 1'b0;
        end else if (i_cmd.start) begin
            r_pos   <= '0;
            r_ramp  <= '0;
            r_key   <= '0;
            r_ratio <= '0;
            r_wrap  <= '0;
            if (r_fin == '0) begin
                r_mode   <= MODE_PLAY;
                r_weight <= tgt_eff;
            end else begin
                r_mode   <= MODE_FADE_IN;
                r_weight <= '0;
            end
        end else if (i_cmd.wrap) begin
            r_kneed <= wrap_active;
            if (wrap_active) begin
                r_pos <= wrapped ? pos_wrapped : r_psum;
            end
            if (wrapped) begin
                r_wrap <= r_wrap + 1'b1;
            end
            if (go_out) begin
                r_mode <= MODE_FADE_OUT;
            end
        end else if (i_cmd.ramp) begin
            r_wneed <= 1'b0;
            case (r_mode)
                MODE_FADE_IN: begin
                    if (fin_done) begin
                        r_weight <= tgt_eff;
                        r_mode   <= MODE_PLAY;
                        r_ramp   <= '0;
                    end else begin
                        r_ramp  <= r_rnew;
                        r_wneed <= 1'b1;
                    end
                end
                MODE_FADE_OUT: begin
                    r_ramp <= r_rnew;
                    if (fo_over) begin
                        r_mode   <= MODE_STOP;
                        r_weight <= '0;
                    end else if (r_fot == '0) begin
                        r_weight <= '0;
                    end else begin
                        r_wneed <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.ktake) begin
            r_key   <= r_wrapped ? '0 : div_quot[W_DIVIDEND-1:W_FRAC];
            r_ratio <= div_quot[W_FRAC-1:0];
        end else if (i_cmd.wtake) begin
            r_weight <= div_quot[W_WEIGHT-1:0];
        end
    end

    // Working registers of the word in progress.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_delta <= i_time_delta;
        end
        if (i_cmd.advance) begin
            r_psum <= pos_add[W_TIME] ? TIME_MAX : pos_add[W_TIME-1:0];
            r_rsum <= ramp_add[W_TIME] ? TIME_MAX : ramp_add[W_TIME-1:0];
        end
        if (i_cmd.wrap) begin
            r_wrapped <= wrapped;
            // Entering fade-out restarts the ramp from zero within this tick.
            r_rnew <= go_out ? {{(W_TIME-W_DELTA){1'b0}}, r_delta} : r_rsum;
        end
        if (i_cmd.ramp) begin
            if (r_mode == MODE_FADE_IN) begin
                r_x    <= r_rnew;
                r_wdiv <= r_fin;
            end else begin
                r_x    <= fo_left;
                r_wdiv <= r_fot;
            end
        end
        if (i_cmd.mul) begin
            r_num <= {{W_WEIGHT{1'b0}}, r_x} * {{W_TIME{1'b0}}, tgt_eff};
        end
    end

    // Divider operands. The weight quotient never exceeds one, so the
    // top of the product already sits below the divisor.
    always_comb begin
        div_go = i_cmd.kgo || i_cmd.wgo;
        if (i_cmd.wgo) begin
            div_rem      = r_num[W_PROD-1:W_WEIGHT];
            div_dividend = {r_num[W_WEIGHT-1:0], {(W_DIVIDEND-W_WEIGHT){1'b0}}};
            div_divisor  = r_wdiv;
            div_steps    = WEIGHT_DIV_STEPS;
        end else begin
            div_rem      = '0;
            div_dividend = {r_pos, {W_FRAC{1'b0}}};
            div_divisor  = kper_eff;
            div_steps    = KEY_DIV_STEPS;
        end
    end

    kpc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_rem      (div_rem),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_o_state  <= r_mode;
            r_o_key    <= r_key;
            r_o_frac   <= r_ratio;
            r_o_weight <= r_weight;
            r_o_loops  <= r_wrap;
        end
    end

    assign o_play_state   = r_o_state;
    assign o_key_index    = r_o_key;
    assign o_key_fraction = r_o_frac;
    assign o_blend_weight = r_o_weight;
    assign o_loops_done   = r_o_loops;

    // Status toward the controller.
    always_comb begin
        o_sts.is_start  = (r_op == OP_START);
        o_sts.mode_stop = (r_mode == MODE_STOP);
        o_sts.kneed     = r_kneed;
        o_sts.wneed     = r_wneed;
        o_sts.div_busy  = div_busy;
    end

endmodule

// ===== hw/rtl/kpc_ctrl.sv =====
// ============================================================================
// kpc_ctrl: sequencing controller
// Walks a tick word through advance, clip-end, ramp, product and the
// divisions it needs, then hands the result to the output register.
// ============================================================================
module kpc_ctrl import kpc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADV   = 4'd1;
    localparam logic [3:0] S_WRAP  = 4'd2;
    localparam logic [3:0] S_RAMP  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_KGO   = 4'd5;
    localparam logic [3:0] S_KWAIT = 4'd6;
    localparam logic [3:0] S_WGO   = 4'd7;
    localparam logic [3:0] S_WWAIT = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    // The output register can take a word when empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ADV;
                end
            end
            S_ADV: begin
                if (i_sts.is_start) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DONE;
                end else if (i_sts.mode_stop) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_WRAP;
                end
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = S_RAMP;
            end
            S_RAMP: begin
                o_cmd.ramp = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                if (i_sts.kneed) begin
                    n_state = S_KGO;
                end else if (i_sts.wneed) begin
                    n_state = S_WGO;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_KGO: begin
                o_cmd.kgo = 1'b1;
                n_state   = S_KWAIT;
            end
            S_KWAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.ktake = 1'b1;
                    n_state     = i_sts.wneed ? S_WGO : S_DONE;
                end
            end
            S_WGO: begin
                o_cmd.wgo = 1'b1;
                n_state   = S_WWAIT;
            end
            S_WWAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.wtake = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/keyframe_playback_clock_unit.sv =====
// ============================================================================
// keyframe_playback_clock_unit: animation playback clock with crossfade
// Advances a clip position per tick word and reports key, fraction and a
// fading blend weight for each word.
// ============================================================================
// Usage:
//   Input channel (i_valid/o_ready) carries a word of op and time_delta:
//   op start restarts playback, op tick advances it by time_delta.
//   Output channel (o_valid/i_ready) returns one word per input word with
//   play state, key index, key fraction, blend weight and loop count.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while
//   the block is idle; writes take effect on the next word.
//   Words are handled one at a time. A start word, or a tick while stopped,
//   skips the arithmetic. A tick in play runs the key division; a tick in
//   fade-in runs the key and weight divisions, or only the key division when
//   it ends the fade-in. A tick in fade-out runs the weight division, or none
//   when its ramp runs out or the fade-out time is zero; a tick that enters
//   fade-out runs both, or only the key division in those cases. The shared
//   radix-2 divider runs 40 steps for key index and fraction, 17 for the
//   weight. The output register lets the next word be accepted while a
//   result waits; a stalled receiver holds the block only when the next
//   result is ready to be written. Reset clears the playback state to
//   stopped with zero weight and loads the defaults.
// ============================================================================
module keyframe_playback_clock_unit import kpc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [W_CFG_IX-1:0] i_cfg_idx,
    input  logic [W_TIME-1:0]   i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_op,
    input  logic [W_DELTA-1:0]  i_time_delta,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [W_STATE-1:0]  o_play_state,
    output logic [W_TIME-1:0]   o_key_index,
    output logic [W_FRAC-1:0]   o_key_fraction,
    output logic [W_WEIGHT-1:0] o_blend_weight,
    output logic [W_LOOPS-1:0]  o_loops_done
);

    t_cmd cmd;
    t_sts sts;

    // Sequencing controller.
    kpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // State, arithmetic and output register.
    kpc_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_time_delta   (i_time_delta),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_play_state   (o_play_state),
        .o_key_index    (o_key_index),
        .o_key_fraction (o_key_fraction),
        .o_blend_weight (o_blend_weight),
        .o_loops_done   (o_loops_done)
    );

endmodule

// ===== hw/rtl/kpc_checker.sv =====
// ============================================================================
// kpc_checker: port-level checks of the keyframe playback clock
// Watches the channels of the top level and flags behavior that the
// design must never show.
// ============================================================================
module kpc_checker import kpc_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input logic [W_STATE-1:0]  o_play_state,
    input logic [W_WEIGHT-1:0] o_blend_weight
);

    // One word at a time: the input closes right after a word is taken.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready stayed high after a word was accepted");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_play_state)
                                   && $stable(o_blend_weight)))
        else $error("stalled result changed or was dropped");

    // The weight never exceeds one.
    a_weight_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_blend_weight <= ONE_Q16))
        else $error("blend weight above one");

    // A stopped clip carries no weight.
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_play_state == MODE_STOP)) |-> (o_blend_weight == '0))
        else $error("nonzero weight while stopped");

endmodule

bind keyframe_playback_clock_unit kpc_checker u_kpc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_play_state   (o_play_state),
    .o_blend_weight (o_blend_weight)
);

// ===== sim/keyframe_playback_clock_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// keyframe_playback_clock_unit_tb: self-checking bench of the playback clock
// A queue of tick and start words feeds a bursty valid/ready driver. A
// behavioral copy of the playback state predicts play state, key, fraction,
// blend weight and loop count for every accepted word. A monitor behind a
// stalling receiver checks each returned word, field by field, against the
// oldest prediction. Directed phases come first, then random phases, each
// under freshly written clip settings.
// ============================================================================
module keyframe_playback_clock_unit_tb;
    import kpc_pkg::*;

    // One returned word, in output field order.
    typedef struct packed {
        logic [W_STATE-1:0]  play_state;
        logic [W_TIME-1:0]   key_index;
        logic [W_FRAC-1:0]   key_fraction;
        logic [W_WEIGHT-1:0] blend_weight;
        logic [W_LOOPS-1:0]  loops_done;
    } t_pose;

    // One input word.
    typedef struct packed {
        logic               op;
        logic [W_DELTA-1:0] delta;
    } t_word;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                cfg_we   = 1'b0;
    logic [W_CFG_IX-1:0] cfg_idx  = '0;
    logic [W_TIME-1:0]   cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                in_op    = OP_TICK;
    logic [W_DELTA-1:0]  in_delta = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [W_STATE-1:0]  out_play_state;
    logic [W_TIME-1:0]   out_key_index;
    logic [W_FRAC-1:0]   out_key_fraction;
    logic [W_WEIGHT-1:0] out_blend_weight;
    logic [W_LOOPS-1:0]  out_loops_done;

    // Words waiting for the driver and poses waiting for the monitor.
    t_word words_to_send[$];
    t_pose poses_due[$];
    int    words_open = 0;
    int    live_words = 0;
    int    errors     = 0;

    // Driver burst and receiver stall pattern.
    int burst_left  = 0;
    int gap_left    = 0;
    int stall_kind  = 0;
    int stall_span  = 0;
    int hold_left   = 0;

    // Mirror of the configuration registers.
    logic [W_TIME-1:0]   clip_len   = RST_CLIP_LENGTH;
    logic [W_TIME-1:0]   key_per    = RST_KEY_PERIOD;
    logic                loop_on    = RST_LOOP_ENABLE;
    logic [W_TIME-1:0]   fade_in    = RST_FADE_IN_TIME;
    logic [W_TIME-1:0]   fade_out   = RST_FADE_OUT_TIME;
    logic [W_WEIGHT-1:0] tgt_weight = RST_TARGET_WEIGHT;

    // Predicted playback state.
    logic [W_STATE-1:0]  pb_mode   = MODE_STOP;
    logic [W_TIME-1:0]   pb_pos    = '0;
    logic [W_TIME-1:0]   pb_ramp   = '0;
    logic [W_TIME-1:0]   pb_key    = '0;
    logic [W_FRAC-1:0]   pb_frac   = '0;
    logic [W_WEIGHT-1:0] pb_weight = '0;
    logic [W_LOOPS-1:0]  pb_loops  = '0;

    keyframe_playback_clock_unit u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_op           (in_op),
        .i_time_delta   (in_delta),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_play_state   (out_play_state),
        .o_key_index    (out_key_index),
        .o_key_fraction (out_key_fraction),
        .o_blend_weight (out_blend_weight),
        .o_loops_done   (out_loops_done)
    );

    always #1 clk = ~clk;

    // Time sums stop at the largest 24-bit value.
    function automatic logic [W_TIME-1:0] sat_add(input logic [W_TIME-1:0] a,
                                                  input logic [W_DELTA-1:0] b);
        logic [W_TIME:0] s;
        s = {1'b0, a} + b;
        return s[W_TIME] ? TIME_MAX : s[W_TIME-1:0];
    endfunction

    // A target above 1.0 acts as 1.0.
    function automatic logic [W_WEIGHT-1:0] full_weight();
        return (tgt_weight > ONE_Q16) ? ONE_Q16 : tgt_weight;
    endfunction

    // A zero key period acts as one tick.
    function automatic logic [W_TIME-1:0] period_div();
        return (key_per == '0) ? W_TIME'(1) : key_per;
    endfunction

    // Q0.16 share of the way from one key to the next.
    function automatic logic [W_FRAC-1:0] key_share(input logic [W_TIME-1:0] pos);
        longint unsigned p;
        longint unsigned rem;
        p = period_div();
        rem = pos % p;
        return W_FRAC'((rem << 16) / p);
    endfunction

    // Fade-out ramp: the weight falls linearly and the clip stops past the end.
    task automatic fade_out_advance(input logic [W_DELTA-1:0] delta);
        longint unsigned num;
        pb_ramp = sat_add(pb_ramp, delta);
        if (pb_ramp > fade_out) begin
            pb_mode   = MODE_STOP;
            pb_weight = '0;
        end else if (fade_out == '0) begin
            pb_weight = '0;
        end else begin
            num = full_weight();
            num = num * (fade_out - pb_ramp);
            pb_weight = W_WEIGHT'(num / fade_out);
        end
    endtask

    // Applies one accepted word to the predicted state and queues the pose.
    task automatic advance_playback(input logic op, input logic [W_DELTA-1:0] delta);
        longint unsigned num;
        live_words++;
        if (op == OP_START) begin
            pb_pos   = '0;
            pb_ramp  = '0;
            pb_key   = '0;
            pb_frac  = '0;
            pb_loops = '0;
            if (fade_in == '0) begin
                pb_mode   = MODE_PLAY;
                pb_weight = full_weight();
            end else begin
                pb_mode   = MODE_FADE_IN;
                pb_weight = '0;
            end
        end else if (pb_mode == MODE_FADE_IN || pb_mode == MODE_PLAY) begin
            pb_pos = sat_add(pb_pos, delta);
            if (pb_pos > clip_len) begin
                // Clip end: one wrap, key back to zero.
                pb_loops = pb_loops + 1'b1;
                pb_pos   = pb_pos - clip_len;
                pb_frac  = key_share(pb_pos);
                pb_key   = '0;
                if (!loop_on) begin
                    pb_mode = MODE_FADE_OUT;
                    pb_ramp = '0;
                end
            end else begin
                pb_key  = pb_pos / period_div();
                pb_frac = key_share(pb_pos);
            end
            if (pb_mode == MODE_FADE_IN) begin
                pb_ramp = sat_add(pb_ramp, delta);
                if (pb_ramp < fade_in) begin
                    num = pb_ramp;
                    num = num * full_weight();
                    pb_weight = W_WEIGHT'(num / fade_in);
                end else begin
                    pb_weight = full_weight();
                    pb_mode   = MODE_PLAY;
                    pb_ramp   = '0;
                end
            end else if (pb_mode == MODE_FADE_OUT) begin
                fade_out_advance(delta);
            end
        end else if (pb_mode == MODE_FADE_OUT) begin
            fade_out_advance(delta);
        end
        poses_due.insert(poses_due.size(),
                         {pb_mode, pb_key, pb_frac, pb_weight, pb_loops});
    endtask

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        errors++;
        if (errors <= 50)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Word driver: bursts of words with random gaps between them.
    always @(posedge clk) begin : word_driver
        t_word w;
        logic  taken;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            taken = in_valid && in_ready;
            if (taken) advance_playback(in_op, in_delta);
            if (!in_valid || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (words_to_send.size() > 0) begin
                    w = words_to_send.pop_front();
                    in_valid <= 1'b1;
                    in_op    <= w.op;
                    in_delta <= w.delta;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Pose monitor: checks returned words and stalls the receiver.
    always @(posedge clk) begin : pose_monitor
        t_pose want;
        t_pose got;
        logic  next_ready;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got = {out_play_state, out_key_index, out_key_fraction,
                       out_blend_weight, out_loops_done};
                if (poses_due.size() == 0) begin
                    report_mismatch("result without a pending word, play state",
                                    0, got.play_state);
                end else begin
                    want = poses_due.pop_front();
                    words_open--;
                    if (got.play_state !== want.play_state)
                        report_mismatch("play state", want.play_state, got.play_state);
                    if (got.key_index !== want.key_index)
                        report_mismatch("key index", want.key_index, got.key_index);
                    if (got.key_fraction !== want.key_fraction)
                        report_mismatch("key fraction", want.key_fraction, got.key_fraction);
                    if (got.blend_weight !== want.blend_weight)
                        report_mismatch("blend weight", want.blend_weight, got.blend_weight);
                    if (got.loops_done !== want.loops_done)
                        report_mismatch("loops done", want.loops_done, got.loops_done);
                end
            end
            // Stall pattern: always ready, coin flips, or long holds.
            if (stall_span == 0) begin
                stall_kind = $urandom_range(0, 2);
                stall_span = $urandom_range(64, 256);
            end else begin
                stall_span--;
            end
            case (stall_kind)
                0: next_ready = 1'b1;
                1: next_ready = 1'($urandom_range(0, 1));
                default: begin
                    if (hold_left > 0) begin
                        hold_left--;
                        next_ready = 1'b0;
                    end else begin
                        next_ready = 1'b1;
                        if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 20);
                    end
                end
            endcase
            out_ready <= next_ready;
        end
    end

    task automatic queue_word(input logic op, input logic [W_DELTA-1:0] delta);
        words_to_send.insert(words_to_send.size(), t_word'{op: op, delta: delta});
        words_open++;
    endtask

    // Register write; the mirror follows at once since no word is in flight.
    task automatic write_reg(input logic [W_CFG_IX-1:0] idx, input logic [W_TIME-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_CLIP_LENGTH:   clip_len   = val;
            CFG_KEY_PERIOD:    key_per    = val;
            CFG_LOOP_ENABLE:   loop_on    = val[0];
            CFG_FADE_IN_TIME:  fade_in    = val;
            CFG_FADE_OUT_TIME: fade_out   = val;
            CFG_TARGET_WEIGHT: tgt_weight = val[W_WEIGHT-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (words_open != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Tick length drawn around the phase's step size.
    function automatic logic [W_DELTA-1:0] pick_delta(input int unsigned step);
        int unsigned top;
        top = (step * 2 > 65535) ? 65535 : step * 2;
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return W_DELTA'($urandom);
            default: return W_DELTA'($urandom_range(0, top));
        endcase
    endfunction

    // New clip settings; step is a tick length that reaches the clip end.
    task automatic pick_settings(output int unsigned step);
        int unsigned clip, per, fin, fout, tw, span;
        case ($urandom_range(0, 15))
            0:       clip = 0;
            1:       clip = 1;
            2:       clip = 24'hFFFFFF;
            3:       clip = $urandom_range(1, 24'hFFFFFF);
            default: clip = $urandom_range(1, 400000);
        endcase
        step = (clip == 0) ? $urandom_range(1, 65535) : clip / $urandom_range(3, 40);
        if (step == 0) step = 1;
        if (step > 65535) step = 65535;
        span = step * $urandom_range(1, 8);
        case ($urandom_range(0, 9))
            0:       per = 0;
            1:       per = 1;
            2:       per = 24'hFFFFFF;
            3:       per = $urandom_range(1, 24'hFFFFFF);
            default: per = $urandom_range(1, clip / 4 + 1);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: fin = 0;
            3:       fin = 24'hFFFFFF;
            4:       fin = 1;
            default: fin = $urandom_range(1, span);
        endcase
        case ($urandom_range(0, 9))
            0:       fout = 0;
            1:       fout = 24'hFFFFFF;
            2:       fout = 1;
            default: fout = $urandom_range(1, span);
        endcase
        case ($urandom_range(0, 9))
            0:       tw = 0;
            1:       tw = 65536;
            2:       tw = 131071;
            3:       tw = $urandom_range(65537, 131071);
            default: tw = $urandom_range(0, 65536);
        endcase
        write_reg(CFG_CLIP_LENGTH, W_TIME'(clip));
        write_reg(CFG_KEY_PERIOD, W_TIME'(per));
        write_reg(CFG_LOOP_ENABLE, W_TIME'($urandom_range(0, 1)));
        write_reg(CFG_FADE_IN_TIME, W_TIME'(fin));
        write_reg(CFG_FADE_OUT_TIME, W_TIME'(fout));
        write_reg(CFG_TARGET_WEIGHT, W_TIME'(tw));
    endtask

    // Mostly a start followed by ticks, with stray restarts as noise.
    task automatic random_phase();
        int unsigned step;
        int unsigned n_words;
        pick_settings(step);
        n_words = $urandom_range(20, 120);
        if ($urandom_range(0, 9) != 0) queue_word(OP_START, W_DELTA'($urandom));
        repeat (n_words) begin
            if ($urandom_range(0, 24) == 0) queue_word(OP_START, W_DELTA'($urandom));
            else queue_word(OP_TICK, pick_delta(step));
        end
    endtask

    // Long runs of large ticks drive the position or the fade-out ramp
    // into saturation.
    task automatic saturate_phase(input logic in_fade_out);
        if (in_fade_out) begin
            write_reg(CFG_CLIP_LENGTH, 1000);
            write_reg(CFG_LOOP_ENABLE, W_TIME'(0));
            write_reg(CFG_FADE_IN_TIME, 0);
            write_reg(CFG_FADE_OUT_TIME, 24'hFFFFFF);
        end else begin
            write_reg(CFG_CLIP_LENGTH, 24'hFFFFFF);
            write_reg(CFG_LOOP_ENABLE, W_TIME'(1));
            write_reg(CFG_FADE_IN_TIME, 24'hFFFFFF);
            write_reg(CFG_KEY_PERIOD, W_TIME'($urandom_range(1, 24'hFFFFFF)));
        end
        write_reg(CFG_TARGET_WEIGHT, W_TIME'($urandom_range(0, 131071)));
        queue_word(OP_START, W_DELTA'($urandom));
        repeat (300) queue_word(OP_TICK, W_DELTA'($urandom_range(60000, 65535)));
    endtask

    initial begin : stimulus
        int phase_no;
        phase_no = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: a tick while stopped, play to the end, fade out, stop.
        queue_word(OP_TICK, 16'hFFFF);
        queue_word(OP_START, 16'h0000);
        queue_word(OP_TICK, 16'h0000);
        queue_word(OP_TICK, 16'hFFFF);
        queue_word(OP_TICK, 16'd2);
        queue_word(OP_TICK, 16'd3000);
        queue_word(OP_TICK, 16'd4000);
        queue_word(OP_TICK, 16'd1);
        wait_idle();

        // Looping clip with a fade-in, a zero key period and a target above one.
        write_reg(CFG_LOOP_ENABLE, W_TIME'(1));
        write_reg(CFG_FADE_IN_TIME, 60000);
        write_reg(CFG_KEY_PERIOD, 0);
        write_reg(CFG_TARGET_WEIGHT, 131071);
        write_reg(CFG_CLIP_LENGTH, 100000);
        queue_word(OP_START, 16'h5A5A);
        queue_word(OP_TICK, 16'd30000);
        queue_word(OP_TICK, 16'd0);
        wait_idle();

        // Fade-in shortened below the ramp already run: play at the next tick.
        write_reg(CFG_FADE_IN_TIME, 10);
        write_reg(CFG_CLIP_LENGTH, 40000);
        queue_word(OP_TICK, 16'd5);
        queue_word(OP_TICK, 16'd20000);
        wait_idle();

        // Clip shortened under the position with a zero fade-out time.
        write_reg(CFG_LOOP_ENABLE, W_TIME'(0));
        write_reg(CFG_FADE_OUT_TIME, 0);
        write_reg(CFG_CLIP_LENGTH, 5);
        queue_word(OP_TICK, 16'd0);
        queue_word(OP_TICK, 16'd0);
        queue_word(OP_TICK, 16'd1);
        wait_idle();

        // Zero clip, widest key period, zero target, endless fade-out.
        write_reg(CFG_KEY_PERIOD, 24'hFFFFFF);
        write_reg(CFG_FADE_OUT_TIME, 24'hFFFFFF);
        write_reg(CFG_TARGET_WEIGHT, 0);
        write_reg(CFG_CLIP_LENGTH, 0);
        write_reg(CFG_FADE_IN_TIME, 0);
        queue_word(OP_START, 16'hA5A5);
        queue_word(OP_TICK, 16'd7);
        queue_word(OP_TICK, 16'hFFFF);
        wait_idle();

        // Random phases until enough words have been sent.
        while (live_words < 1900) begin
            phase_no++;
            if (phase_no == 6) saturate_phase(1'b0);
            else if (phase_no == 12) saturate_phase(1'b1);
            else random_phase();
            wait_idle();
        end

        if (poses_due.size() != 0)
            report_mismatch("poses left over", 0, poses_due.size());
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
